@@ hdl/pcoc_pkg.sv @@
`default_nettype none
package pcoc_pkg;

  // field widths fixed by the interface
  localparam int SAMPLE_W  = 16;
  localparam int WARMUP_W  = 8;
  localparam int RETRY_W   = 4;
  localparam int FAIL_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // reset values of the configuration registers
  localparam logic [WARMUP_W-1:0] WARMUP_RST      = 8'd200;
  localparam logic [15:0]         PHASE_LIMIT_RST = 16'd5120;
  localparam logic [RETRY_W-1:0]  RETRY_LIMIT_RST = 4'd5;
  localparam logic [15:0]         BRAKE_LIMIT_RST = 16'd3971;

  // most negative average is pulled in by one
  localparam logic signed [SAMPLE_W-1:0] AVG_MIN     = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] AVG_MIN_FIX = 16'sh8001;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WARMUP_TICKS = 2'd0,
    CFG_PHASE_LIMIT  = 2'd1,
    CFG_RETRY_LIMIT  = 2'd2,
    CFG_BRAKE_LIMIT  = 2'd3
  } cfg_reg_t;

endpackage
`default_nettype wire

@@ hdl/phase_current_offset_calibrator.sv @@
`default_nettype none
// An accepted input word passes through the input register, then the result register;
// the stored state updates in the same step as the result register is loaded.
// One word per cycle unless out_tready stalls; set by the single accumulate/compare step.
// Reset (rst_n low, synchronous): both pipeline stages empty, all sums, counts,
// offsets and flags cleared, configuration registers back to their defaults.
module phase_current_offset_calibrator #(
  parameter int PHASE_WINDOW_LOG2 = 5,
  parameter int BRAKE_WINDOW_LOG2 = 9
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // current_u, current_v, current_w, current_brake
  input  wire logic [0:0]  in_tuser,   // idle
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // offset_u, offset_v, offset_w, offset_brake
  output logic [3:0]       out_tuser,  // run_enable, current_fault, brake_fault, brake_ok
  // configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pcoc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pcoc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pcoc_pkg::*;

  localparam int PSUM_W = SAMPLE_W + PHASE_WINDOW_LOG2;
  localparam int BSUM_W = SAMPLE_W + BRAKE_WINDOW_LOG2;
  localparam int PCNT_W = PHASE_WINDOW_LOG2 + 1;
  localparam int BCNT_W = BRAKE_WINDOW_LOG2 + 1;

  // configuration registers
  logic [WARMUP_W-1:0] warmup_ticks_r;
  logic [15:0]         phase_limit_r;
  logic [RETRY_W-1:0]  retry_limit_r;
  logic [15:0]         brake_limit_r;

  // input stage
  logic                       s1_valid_r;
  logic                       s1_idle_r;
  logic signed [SAMPLE_W-1:0] s1_u_r, s1_v_r, s1_w_r;
  logic [SAMPLE_W-1:0]        s1_brake_r;

  // calibration state
  logic [WARMUP_W-1:0]      warmup_count_r, warmup_count_nxt;
  logic signed [PSUM_W-1:0] sum_u_r, sum_v_r, sum_w_r;
  logic signed [PSUM_W-1:0] sum_u_nxt, sum_v_nxt, sum_w_nxt;
  logic [PCNT_W-1:0]        phase_count_r, phase_count_nxt;
  logic [BSUM_W-1:0]        sum_brake_r, sum_brake_nxt;
  logic [BCNT_W-1:0]        brake_count_r, brake_count_nxt;
  logic [FAIL_W-1:0]        fail_count_r, fail_count_nxt;
  logic signed [SAMPLE_W-1:0] off_u_r, off_v_r, off_w_r;
  logic signed [SAMPLE_W-1:0] off_u_nxt, off_v_nxt, off_w_nxt;
  logic [SAMPLE_W-1:0]      off_brake_r, off_brake_nxt;
  logic                     run_en_r, run_en_nxt;
  logic                     brake_ok_r, brake_ok_nxt;
  logic                     brake_cal_r, brake_cal_nxt;
  logic                     cur_fault, brk_fault;

  // result register
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [3:0]  out_user_r;

  logic advance;
  logic step;

  // pipeline moves when the result register is free or being emptied
  assign advance   = !out_valid_r || out_tready;
  assign step      = advance && s1_valid_r;
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // floor average with the most negative code pulled in
  function automatic logic signed [SAMPLE_W-1:0] clamp_avg(
    input logic signed [SAMPLE_W-1:0] a
  );
    clamp_avg = (a == AVG_MIN) ? AVG_MIN_FIX : a;
  endfunction

  function automatic logic [SAMPLE_W-1:0] magnitude(input logic signed [SAMPLE_W-1:0] a);
    magnitude = a[SAMPLE_W-1] ? SAMPLE_W'(-a) : SAMPLE_W'(a);
  endfunction

  // accumulated sums including this sample
  logic signed [PSUM_W-1:0]   acc_u, acc_v, acc_w;
  logic [BSUM_W-1:0]          acc_brake;
  logic [PCNT_W-1:0]          pcnt_inc;
  logic [BCNT_W-1:0]          bcnt_inc;
  logic signed [SAMPLE_W-1:0] avg_u, avg_v, avg_w;
  logic [SAMPLE_W-1:0]        avg_brake;
  logic                       phase_pass;
  logic [WARMUP_W:0]          warm_inc;
  logic [WARMUP_W-1:0]        warm_sat;

  assign acc_u = sum_u_r + {{PHASE_WINDOW_LOG2{s1_u_r[SAMPLE_W-1]}}, s1_u_r};
  assign acc_v = sum_v_r + {{PHASE_WINDOW_LOG2{s1_v_r[SAMPLE_W-1]}}, s1_v_r};
  assign acc_w = sum_w_r + {{PHASE_WINDOW_LOG2{s1_w_r[SAMPLE_W-1]}}, s1_w_r};
  assign acc_brake = sum_brake_r + {{BRAKE_WINDOW_LOG2{1'b0}}, s1_brake_r};
  assign pcnt_inc  = phase_count_r + PCNT_W'(1);
  assign bcnt_inc  = brake_count_r + BCNT_W'(1);

  assign avg_u = clamp_avg(acc_u[PSUM_W-1:PHASE_WINDOW_LOG2]);
  assign avg_v = clamp_avg(acc_v[PSUM_W-1:PHASE_WINDOW_LOG2]);
  assign avg_w = clamp_avg(acc_w[PSUM_W-1:PHASE_WINDOW_LOG2]);
  assign avg_brake = acc_brake[BSUM_W-1:BRAKE_WINDOW_LOG2];

  assign phase_pass = (magnitude(avg_u) < phase_limit_r) &&
                      (magnitude(avg_v) < phase_limit_r) &&
                      (magnitude(avg_w) < phase_limit_r);

  // warm-up counter saturates at the programmed count
  assign warm_inc = {1'b0, warmup_count_r} + (WARMUP_W+1)'(1);
  assign warm_sat = (warm_inc > {1'b0, warmup_ticks_r}) ? warmup_ticks_r
                                                         : warm_inc[WARMUP_W-1:0];

  // next state for one sample word
  always_comb begin
    warmup_count_nxt = warmup_count_r;
    sum_u_nxt        = sum_u_r;
    sum_v_nxt        = sum_v_r;
    sum_w_nxt        = sum_w_r;
    phase_count_nxt  = phase_count_r;
    sum_brake_nxt    = sum_brake_r;
    brake_count_nxt  = brake_count_r;
    fail_count_nxt   = fail_count_r;
    off_u_nxt        = off_u_r;
    off_v_nxt        = off_v_r;
    off_w_nxt        = off_w_r;
    off_brake_nxt    = off_brake_r;
    run_en_nxt       = run_en_r;
    brake_ok_nxt     = brake_ok_r;
    brake_cal_nxt    = brake_cal_r;
    cur_fault        = 1'b0;
    brk_fault        = 1'b0;
    if (!s1_idle_r) begin
      warmup_count_nxt = '0;
    end else begin
      warmup_count_nxt = warm_sat;
      if (warm_sat < warmup_ticks_r) begin
        // still warming up: hold the sums, window counts and brake ok cleared
        sum_u_nxt       = '0;
        sum_v_nxt       = '0;
        sum_w_nxt       = '0;
        phase_count_nxt = '0;
        sum_brake_nxt   = '0;
        brake_count_nxt = '0;
        brake_ok_nxt    = 1'b0;
      end else begin
        sum_u_nxt       = acc_u;
        sum_v_nxt       = acc_v;
        sum_w_nxt       = acc_w;
        phase_count_nxt = pcnt_inc;
        sum_brake_nxt   = acc_brake;
        brake_count_nxt = bcnt_inc;

        // phase window complete
        if (pcnt_inc[PHASE_WINDOW_LOG2]) begin
          sum_u_nxt       = '0;
          sum_v_nxt       = '0;
          sum_w_nxt       = '0;
          phase_count_nxt = '0;
          if (phase_pass) begin
            off_u_nxt      = avg_u;
            off_v_nxt      = avg_v;
            off_w_nxt      = avg_w;
            fail_count_nxt = '0;
            run_en_nxt     = 1'b1;
          end else if (fail_count_r > {1'b0, retry_limit_r}) begin
            cur_fault        = 1'b1;
            fail_count_nxt   = '0;
            warmup_count_nxt = '0;
            run_en_nxt       = 1'b0;
          end else begin
            fail_count_nxt = fail_count_r + FAIL_W'(1);
          end
        end

        // brake window complete
        if (bcnt_inc[BRAKE_WINDOW_LOG2]) begin
          sum_brake_nxt   = '0;
          brake_count_nxt = '0;
          if (brake_cal_r) begin
            brake_ok_nxt = 1'b1;
          end else if (avg_brake < brake_limit_r) begin
            off_brake_nxt = avg_brake;
            brake_ok_nxt  = 1'b1;
            brake_cal_nxt = 1'b1;
          end else if (!brake_ok_r) begin
            brk_fault        = 1'b1;
            warmup_count_nxt = '0;
          end
        end
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warmup_ticks_r <= WARMUP_RST;
      phase_limit_r  <= PHASE_LIMIT_RST;
      retry_limit_r  <= RETRY_LIMIT_RST;
      brake_limit_r  <= BRAKE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WARMUP_TICKS: warmup_ticks_r <= cfg_data[WARMUP_W-1:0];
        CFG_PHASE_LIMIT:  phase_limit_r  <= cfg_data;
        CFG_RETRY_LIMIT:  retry_limit_r  <= cfg_data[RETRY_W-1:0];
        CFG_BRAKE_LIMIT:  brake_limit_r  <= cfg_data;
        default:          ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_idle_r  <= in_tuser[0];
      s1_u_r     <= in_tdata[15:0];
      s1_v_r     <= in_tdata[31:16];
      s1_w_r     <= in_tdata[47:32];
      s1_brake_r <= in_tdata[63:48];
    end
  end

  // calibration state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warmup_count_r <= '0;
      sum_u_r        <= '0;
      sum_v_r        <= '0;
      sum_w_r        <= '0;
      phase_count_r  <= '0;
      sum_brake_r    <= '0;
      brake_count_r  <= '0;
      fail_count_r   <= '0;
      off_u_r        <= '0;
      off_v_r        <= '0;
      off_w_r        <= '0;
      off_brake_r    <= '0;
      run_en_r       <= 1'b0;
      brake_ok_r     <= 1'b0;
      brake_cal_r    <= 1'b0;
    end else if (step) begin
      warmup_count_r <= warmup_count_nxt;
      sum_u_r        <= sum_u_nxt;
      sum_v_r        <= sum_v_nxt;
      sum_w_r        <= sum_w_nxt;
      phase_count_r  <= phase_count_nxt;
      sum_brake_r    <= sum_brake_nxt;
      brake_count_r  <= brake_count_nxt;
      fail_count_r   <= fail_count_nxt;
      off_u_r        <= off_u_nxt;
      off_v_r        <= off_v_nxt;
      off_w_r        <= off_w_nxt;
      off_brake_r    <= off_brake_nxt;
      run_en_r       <= run_en_nxt;
      brake_ok_r     <= brake_ok_nxt;
      brake_cal_r    <= brake_cal_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= {off_brake_nxt, off_w_nxt, off_v_nxt, off_u_nxt};
      out_user_r <= {brake_ok_nxt, brk_fault, cur_fault, run_en_nxt};
    end
  end

  // checks
  a_fault_drops_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0])
    else $error("current fault reported with run enable set");

  a_brake_fault_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> !out_tuser[3])
    else $error("brake fault reported with brake ok set");

  a_phase_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    !phase_count_r[PHASE_WINDOW_LOG2])
    else $error("phase sample count ran past the window");

  a_brake_ok_needs_cal: assert property (@(posedge clk) disable iff (!rst_n)
    brake_ok_r |-> brake_cal_r)
    else $error("brake ok set before brake calibration");

endmodule
`default_nettype wire

@@ tb/tb_phase_current_offset_calibrator.sv @@
`default_nettype none
module tb_phase_current_offset_calibrator;
  import pcoc_pkg::*;

  localparam int PH_LOG2  = 5;
  localparam int BRK_LOG2 = 9;
  localparam int HOLD_CYCLES = 120;
  localparam int HOLD_AFTER  = 800;

  // one ADC sample set as it enters the block
  typedef struct {
    logic                 idle;
    logic signed [15:0]   u;
    logic signed [15:0]   v;
    logic signed [15:0]   w;
    logic [15:0]          brake;
  } adc_set_t;

  // one calibration report as it leaves the block
  typedef struct {
    logic signed [15:0]   off_u;
    logic signed [15:0]   off_v;
    logic signed [15:0]   off_w;
    logic [15:0]          off_brake;
    logic                 run_en;
    logic                 cur_fault;
    logic                 brk_fault;
    logic                 brake_ok;
  } calib_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  wire logic   in_tready;
  logic [63:0] in_tdata = '0;   // current_u, current_v, current_w, current_brake
  logic [0:0]  in_tuser = '0;   // idle
  wire logic        out_tvalid;
  logic             out_tready = 1'b0;
  wire logic [63:0] out_tdata;  // offset_u, offset_v, offset_w, offset_brake
  wire logic [3:0]  out_tuser;  // run_enable, current_fault, brake_fault, brake_ok
  logic                  cfg_valid = 1'b0;
  wire logic             cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  phase_current_offset_calibrator #(
    .PHASE_WINDOW_LOG2(PH_LOG2),
    .BRAKE_WINDOW_LOG2(BRK_LOG2)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register copies seen by the predictor
  logic [7:0]  warmup_ticks_r = WARMUP_RST;
  logic [15:0] phase_limit_r  = PHASE_LIMIT_RST;
  logic [3:0]  retry_limit_r  = RETRY_LIMIT_RST;
  logic [15:0] brake_limit_r  = BRAKE_LIMIT_RST;

  // calibration state of the predictor
  int unsigned        warm_cnt = 0;
  longint             acc_u = 0, acc_v = 0, acc_w = 0;
  int unsigned        ph_cnt = 0;
  longint unsigned    acc_brake = 0;
  int unsigned        brk_cnt = 0;
  logic [4:0]         fails = '0;
  logic signed [15:0] st_u = '0, st_v = '0, st_w = '0;
  logic [15:0]        st_brake = '0;
  logic               run_en_q = 1'b0, brake_ok_q = 1'b0, brake_done = 1'b0;

  adc_set_t      adc_sets[$];
  calib_report_t reports_due[$];

  int unsigned mismatches = 0;
  int unsigned words_seen = 0;
  int unsigned accepted_cnt = 0;

  // floor average with the most negative value pulled in by one
  function automatic longint window_avg(longint acc);
    longint a;
    a = acc >>> PH_LOG2;
    if (a == longint'(AVG_MIN)) a = longint'(AVG_MIN_FIX);
    return a;
  endfunction

  function automatic longint magnitude(longint a);
    return (a < 0) ? -a : a;
  endfunction

  // advance the calibration by one sample tick and give the report it yields
  function automatic calib_report_t step_calibration(adc_set_t s);
    calib_report_t r;
    int unsigned   nxt;
    longint        au, av, aw;
    logic [4:0]    prev_fails;
    longint unsigned brk_avg;
    r.cur_fault = 1'b0;
    r.brk_fault = 1'b0;
    if (!s.idle) begin
      warm_cnt = 0;
    end else begin
      nxt = warm_cnt + 1;
      warm_cnt = (nxt > warmup_ticks_r) ? warmup_ticks_r : nxt;
      if (warm_cnt < warmup_ticks_r) begin
        acc_u = 0; acc_v = 0; acc_w = 0; ph_cnt = 0;
        acc_brake = 0; brk_cnt = 0; brake_ok_q = 1'b0;
      end else begin
        acc_u += longint'(s.u);
        acc_v += longint'(s.v);
        acc_w += longint'(s.w);
        ph_cnt++;
        acc_brake += s.brake;
        brk_cnt++;

        // phase window complete
        if (ph_cnt >= (1 << PH_LOG2)) begin
          au = window_avg(acc_u);
          av = window_avg(acc_v);
          aw = window_avg(acc_w);
          acc_u = 0; acc_v = 0; acc_w = 0; ph_cnt = 0;
          if (magnitude(au) < phase_limit_r && magnitude(av) < phase_limit_r &&
              magnitude(aw) < phase_limit_r) begin
            st_u = au[15:0];
            st_v = av[15:0];
            st_w = aw[15:0];
            fails = '0;
            run_en_q = 1'b1;
          end else begin
            prev_fails = fails;
            fails = prev_fails + 5'd1;
            if (prev_fails > retry_limit_r) begin
              r.cur_fault = 1'b1;
              fails = '0;
              warm_cnt = 0;
              run_en_q = 1'b0;
            end
          end
        end

        // brake window complete
        if (brk_cnt >= (1 << BRK_LOG2)) begin
          if (!brake_done) begin
            brk_avg = acc_brake >> BRK_LOG2;
            acc_brake = 0; brk_cnt = 0;
            if (brk_avg < brake_limit_r) begin
              st_brake = brk_avg[15:0];
              brake_ok_q = 1'b1;
              brake_done = 1'b1;
            end else if (!brake_ok_q) begin
              r.brk_fault = 1'b1;
              warm_cnt = 0;
            end
          end else begin
            brake_ok_q = 1'b1;
            acc_brake = 0; brk_cnt = 0;
          end
        end
      end
    end
    r.off_u = st_u;
    r.off_v = st_v;
    r.off_w = st_w;
    r.off_brake = st_brake;
    r.run_en = run_en_q;
    r.brake_ok = brake_ok_q;
    return r;
  endfunction

  // gap lengths: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // long receiver hold-off, once, to back the block up
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  wire logic   rx_hold = (hold_left != 0);

  always @(posedge clk) begin
    if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // sample set driver
  adc_set_t    cur_set;
  int unsigned tx_gap = 0, tx_burst = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        reports_due.push_back(step_calibration(cur_set));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (in_tvalid && !in_tready) begin
        // word still on offer
      end else if (tx_gap != 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (adc_sets.size() != 0) begin
        cur_set = adc_sets.pop_front();
        in_tdata <= {cur_set.brake, cur_set.w, cur_set.v, cur_set.u};
        in_tuser <= cur_set.idle;
        in_tvalid <= 1'b1;
        if (tx_burst != 0) tx_burst--;
        else if ($urandom_range(0, 49) == 0) tx_burst = $urandom_range(30, 80);
        tx_gap = (tx_burst != 0 || rx_hold) ? 0 : pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("mismatch in %s of word %0d: expected %h, got %h", fname, words_seen,
                 want, got);
      mismatches++;
    end
  endtask

  // report monitor
  calib_report_t want_rep;
  int unsigned   rx_stall = 0, rx_burst = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (reports_due.size() == 0) begin
          if (mismatches < 10) $display("report word %0d arrived with none due", words_seen);
          mismatches++;
        end else begin
          want_rep = reports_due.pop_front();
          check_field("offset_u", want_rep.off_u, out_tdata[15:0]);
          check_field("offset_v", want_rep.off_v, out_tdata[31:16]);
          check_field("offset_w", want_rep.off_w, out_tdata[47:32]);
          check_field("offset_brake", want_rep.off_brake, out_tdata[63:48]);
          check_field("run_enable", 16'(want_rep.run_en), 16'(out_tuser[0]));
          check_field("current_fault", 16'(want_rep.cur_fault), 16'(out_tuser[1]));
          check_field("brake_fault", 16'(want_rep.brk_fault), 16'(out_tuser[2]));
          check_field("brake_ok", 16'(want_rep.brake_ok), 16'(out_tuser[3]));
        end
        words_seen++;
        if (rx_burst != 0) rx_burst--;
        else if ($urandom_range(0, 49) == 0) rx_burst = $urandom_range(30, 80);
        rx_stall = (rx_burst != 0) ? 0 : pick_gap();
      end else if (rx_stall != 0) begin
        rx_stall--;
      end
      out_tready <= !rx_hold && rx_stall == 0;
    end
  end

  task automatic add_set(logic idle, int u, int v, int w, int brake);
    adc_set_t s;
    s.idle = idle;
    s.u = 16'(u);
    s.v = 16'(v);
    s.w = 16'(w);
    s.brake = 16'(brake);
    adc_sets.push_back(s);
  endtask

  // write all four registers back to back while the block is quiet
  task automatic write_cfg(logic [7:0] warm, logic [15:0] plim, logic [3:0] rlim,
                           logic [15:0] blim);
    cfg_reg_t    regs[4] = '{CFG_WARMUP_TICKS, CFG_PHASE_LIMIT, CFG_RETRY_LIMIT,
                             CFG_BRAKE_LIMIT};
    logic [15:0] vals[4];
    vals = '{16'(warm), plim, 16'(rlim), blim};
    for (int k = 0; k < 4; k++) begin
      cfg_index <= regs[k];
      cfg_data <= vals[k];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      case (regs[k])
        CFG_WARMUP_TICKS: warmup_ticks_r = vals[k][7:0];
        CFG_PHASE_LIMIT:  phase_limit_r = vals[k];
        CFG_RETRY_LIMIT:  retry_limit_r = vals[k][3:0];
        CFG_BRAKE_LIMIT:  brake_limit_r = vals[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // random sample sets, content chosen per phase window so averages land
  // around the limits, on the rails and at the most negative value
  task automatic fill_random(int unsigned count, int unsigned busy_permille);
    int unsigned ph_mode, bk_mode;
    int cu, cv, cw;
    int u, v, w, b;
    ph_mode = 0;
    bk_mode = 0;
    cu = 0; cv = 0; cw = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        ph_mode = $urandom_range(0, 3);
        bk_mode = $urandom_range(0, 1);
        cu = $urandom_range(0, 14000) - 7000;
        cv = $urandom_range(0, 14000) - 7000;
        cw = $urandom_range(0, 14000) - 7000;
      end
      case (ph_mode)
        0: begin
          u = cu + $urandom_range(0, 64) - 32;
          v = cv + $urandom_range(0, 64) - 32;
          w = cw + $urandom_range(0, 64) - 32;
        end
        1: begin
          u = $urandom_range(0, 65535);
          v = $urandom_range(0, 65535);
          w = $urandom_range(0, 65535);
        end
        2: begin
          u = -32768 + $urandom_range(0, 1);
          v = -32768 + $urandom_range(0, 1);
          w = -32768;
        end
        default: begin
          u = 32767 - $urandom_range(0, 1);
          v = 32767;
          w = 32767 - $urandom_range(0, 1);
        end
      endcase
      b = (bk_mode == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 65535);
      add_set($urandom_range(0, 999) >= busy_permille, u, v, w, b);
    end
  endtask

  // sampled away from the driving edge so a word just loaded is seen
  task automatic wait_quiet();
    do @(negedge clk);
    while (adc_sets.size() != 0 || in_tvalid || reports_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // stimulus sequence
  initial begin
    int rails[4] = '{-32768, 32767, 0, -1};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // extremes under reset settings, inside warm-up, idle and running
    for (int k = 0; k < 24; k++)
      add_set(k % 6 != 5, rails[k % 4], rails[(k + 1) % 4], rails[(k + 2) % 4],
              (k % 4 < 2) ? 65535 : 0);
    wait_quiet();

    // no warm-up, every window fails, brake always out of range;
    // phase fault and brake window meet on one tick
    write_cfg(8'd0, 16'd0, 4'd0, 16'd0);
    fill_random(520, 5);
    wait_quiet();

    // widest limits, brake passes and becomes calibrated
    write_cfg(8'd1, 16'd32768, 4'd15, 16'd65535);
    fill_random(520, 5);
    wait_quiet();

    // random settings, long enough for a window after calibration
    write_cfg(8'($urandom_range(1, 8)), 16'($urandom_range(0, 32768)),
              4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
    fill_random(530, 0);
    wait_quiet();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
`default_nettype wire
